### rtl/tpag_pkg.sv
`default_nettype none

package tpag_pkg;

	// Configuration port geometry
	localparam int NUM_REGS       = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 13;
	localparam int AXIS_CNT_W     = 3;
	localparam int CFG_EXT_W      = 13;
	localparam int PERM_W         = 8;
	localparam int NUM_EXT_REGS   = 4;
	localparam int NUM_PERM_FLDS  = 4;
	localparam int PERM_FLD_W     = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERM_MAP   = 3'd5;

	// Register reset values
	localparam logic [AXIS_CNT_W-1:0] AXIS_COUNT_RST = 3'd4;
	localparam logic [CFG_EXT_W-1:0]  EXTENT_RST     = 13'd1;
	localparam logic [PERM_W-1:0]     PERM_MAP_RST   = 8'd228;

	// Destination index width
	localparam int IDX_W = 48;

	// Decoupling queue between counter front and index pipeline
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Parameter defaults
	localparam int MAX_AXES_DEF    = 4;
	localparam int EXTENT_BITS_DEF = 12;
	localparam int DATA_BITS_DEF   = 32;

endpackage

`default_nettype wire

### rtl/tpag_if.sv
`default_nettype none

// Element stream into the block
interface tpag_in_if #(
	parameter int DATA_BITS = tpag_pkg::DATA_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] elem_data;

	modport source (output valid, output elem_data, input ready);
	modport sink   (input valid, input elem_data, output ready);
endinterface

// Element stream with destination index out of the block
interface tpag_out_if #(
	parameter int DATA_BITS = tpag_pkg::DATA_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic [tpag_pkg::IDX_W-1:0] dest_index;
	logic [DATA_BITS-1:0]       out_data;
	logic                       last;

	modport source (output valid, output dest_index, output out_data, output last, input ready);
	modport sink   (input valid, input dest_index, input out_data, input last, output ready);
endinterface

`default_nettype wire

### rtl/tpag_cfg.sv
`default_nettype none

module tpag_cfg #(
	parameter int MAX_AXES    = tpag_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS_DEF,
	localparam int AIW        = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      wr_en,
	input  wire logic [tpag_pkg::CFG_IDX_W-1:0]            wr_index,
	input  wire logic [tpag_pkg::CFG_DATA_W-1:0]           wr_data,
	output logic      [MAX_AXES-1:0]                       axis_use,
	output logic      [MAX_AXES-1:0][EXTENT_BITS:0]        ext_eff,
	output logic      [MAX_AXES-1:0][EXTENT_BITS:0]        perm_ext,
	output logic      [MAX_AXES-1:0][AIW-1:0]              perm_src,
	output logic      [MAX_AXES-1:0]                       perm_use
);
	import tpag_pkg::*;

	localparam int EXT_W = EXTENT_BITS + 1;
	localparam int AXW   = $clog2(MAX_AXES + 1);
	localparam int NW    = (AXW > AXIS_CNT_W) ? AXW : AXIS_CNT_W;
	localparam int PW    = (AXW > PERM_FLD_W) ? AXW : PERM_FLD_W;
	localparam int CMP_W = (EXT_W > CFG_EXT_W) ? EXT_W : CFG_EXT_W;
	localparam logic [CMP_W-1:0] EXT_TOP = {{(CMP_W-1){1'b0}}, 1'b1} << EXTENT_BITS;

	logic [AXIS_CNT_W-1:0] axis_cnt_q;
	logic [CFG_EXT_W-1:0]  ext_q [NUM_EXT_REGS];
	logic [PERM_W-1:0]     perm_q;
	logic [NW-1:0]         cnt_w;
	logic [AXW-1:0]        n_eff;

	// Hold the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_cnt_q <= AXIS_COUNT_RST;
			for (int k = 0; k < NUM_EXT_REGS; k++) begin
				ext_q[k] <= EXTENT_RST;
			end
			perm_q <= PERM_MAP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_AXIS_COUNT: axis_cnt_q <= wr_data[AXIS_CNT_W-1:0];
				REG_EXTENT_0:   ext_q[0]   <= wr_data[CFG_EXT_W-1:0];
				REG_EXTENT_1:   ext_q[1]   <= wr_data[CFG_EXT_W-1:0];
				REG_EXTENT_2:   ext_q[2]   <= wr_data[CFG_EXT_W-1:0];
				REG_EXTENT_3:   ext_q[3]   <= wr_data[CFG_EXT_W-1:0];
				REG_PERM_MAP:   perm_q     <= wr_data[PERM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the axis count to 1..MAX_AXES
	always_comb begin
		cnt_w = NW'(axis_cnt_q);
		if (axis_cnt_q == '0) begin
			n_eff = AXW'(1);
		end else if (cnt_w > NW'(MAX_AXES)) begin
			n_eff = AXW'(MAX_AXES);
		end else begin
			n_eff = AXW'(cnt_w);
		end
	end

	// Source axes: in-use mask and clamped extents
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
		assign axis_use[a] = AXW'(a) < n_eff;
		if (a < NUM_EXT_REGS) begin : g_reg
			logic [CMP_W-1:0] raw_w;
			logic [CMP_W-1:0] sat_w;
			always_comb begin
				raw_w = CMP_W'(ext_q[a]);
				if (raw_w == '0) begin
					sat_w = CMP_W'(1);
				end else if (raw_w > EXT_TOP) begin
					sat_w = EXT_TOP;
				end else begin
					sat_w = raw_w;
				end
				ext_eff[a] = axis_use[a] ? EXT_W'(sat_w) : EXT_W'(1);
			end
		end else begin : g_noreg
			assign ext_eff[a] = EXT_W'(1);
		end
	end

	// Output axes: source select and permuted extent
	for (genvar i = 0; i < MAX_AXES; i++) begin : g_perm
		logic [PERM_FLD_W-1:0] fld;
		if (i < NUM_PERM_FLDS) begin : g_fld
			assign fld = perm_q[PERM_FLD_W*i +: PERM_FLD_W];
		end else begin : g_nofld
			assign fld = '0;
		end
		assign perm_use[i] = axis_use[i] && (PW'(fld) < PW'(n_eff));
		assign perm_src[i] = AIW'(fld);
		assign perm_ext[i] = perm_use[i] ? ext_eff[perm_src[i]] : EXT_W'(1);
	end

endmodule

`default_nettype wire

### rtl/tpag_front.sv
`default_nettype none

module tpag_front #(
	parameter int MAX_AXES    = tpag_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS_DEF,
	parameter int DATA_BITS   = tpag_pkg::DATA_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	tpag_in_if.sink                                     src,
	input  wire logic [MAX_AXES-1:0]                    axis_use,
	input  wire logic [MAX_AXES-1:0][EXTENT_BITS:0]     ext_eff,
	output logic                                        push_valid,
	input  wire logic                                   push_ready,
	output logic      [MAX_AXES-1:0][EXTENT_BITS-1:0]   push_coord,
	output logic      [DATA_BITS-1:0]                   push_data,
	output logic                                        push_last
);
	import tpag_pkg::*;

	localparam int EXT_W = EXTENT_BITS + 1;

	logic [MAX_AXES-1:0][EXTENT_BITS-1:0] coord_q;
	logic [MAX_AXES-1:0][EXTENT_BITS-1:0] coord_nxt;
	logic [MAX_AXES-1:0]                  wrap;
	logic [MAX_AXES-1:0]                  carry;
	logic                                 last;
	logic                                 accept;

	// Classify each axis: at its end or not, and ripple the carry outward
	always_comb begin
		for (int a = 0; a < MAX_AXES; a++) begin
			wrap[a] = (EXT_W'(coord_q[a]) + EXT_W'(1)) >= ext_eff[a];
		end
		carry[MAX_AXES-1] = 1'b1;
		for (int k = MAX_AXES - 2; k >= 0; k--) begin
			carry[k] = carry[k+1] & wrap[k+1];
		end
		last = &wrap;
		for (int a = 0; a < MAX_AXES; a++) begin
			if (last) begin
				coord_nxt[a] = '0;
			end else if (axis_use[a] && carry[a]) begin
				coord_nxt[a] = wrap[a] ? '0 : coord_q[a] + EXTENT_BITS'(1);
			end else begin
				coord_nxt[a] = coord_q[a];
			end
		end
	end

	assign accept     = src.valid & push_ready;
	assign src.ready  = push_ready;
	assign push_valid = src.valid;
	assign push_data  = src.elem_data;
	assign push_last  = last;

	// Unused axes read as coordinate zero
	always_comb begin
		for (int a = 0; a < MAX_AXES; a++) begin
			push_coord[a] = axis_use[a] ? coord_q[a] : '0;
		end
	end

	// Advance the coordinate counters on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (accept) begin
			coord_q <= coord_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/tpag_queue.sv
`default_nettype none

module tpag_queue #(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);
	import tpag_pkg::*;

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/tpag_back.sv
`default_nettype none

module tpag_back #(
	parameter int MAX_AXES    = tpag_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS_DEF,
	parameter int DATA_BITS   = tpag_pkg::DATA_BITS_DEF,
	localparam int AIW        = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   pop_valid,
	output logic                                        pop_ready,
	input  wire logic [MAX_AXES-1:0][EXTENT_BITS-1:0]   pop_coord,
	input  wire logic [DATA_BITS-1:0]                   pop_data,
	input  wire logic                                   pop_last,
	input  wire logic [MAX_AXES-1:0][EXTENT_BITS:0]     perm_ext,
	input  wire logic [MAX_AXES-1:0][AIW-1:0]           perm_src,
	input  wire logic [MAX_AXES-1:0]                    perm_use,
	tpag_out_if.source                                  dst
);
	import tpag_pkg::*;

	// Stage j holds the Horner sum over output axes 0..j
	logic [MAX_AXES-1:0]                  vld_q;
	logic [MAX_AXES-1:0]                  lst_q;
	logic [IDX_W-1:0]                     acc_q [MAX_AXES];
	logic [MAX_AXES-1:0][EXTENT_BITS-1:0] crd_q [MAX_AXES];
	logic [DATA_BITS-1:0]                 dat_q [MAX_AXES];
	logic [MAX_AXES-1:0]                  rdy;

	// Stage can load when empty or when its content moves on
	always_comb begin
		rdy[MAX_AXES-1] = !vld_q[MAX_AXES-1] | dst.ready;
		for (int j = MAX_AXES - 2; j >= 0; j--) begin
			rdy[j] = !vld_q[j] | rdy[j+1];
		end
	end

	assign pop_ready = rdy[0];

	for (genvar j = 0; j < MAX_AXES; j++) begin : g_stage
		logic                                 in_vld;
		logic                                 in_lst;
		logic [MAX_AXES-1:0][EXTENT_BITS-1:0] in_crd;
		logic [DATA_BITS-1:0]                 in_dat;
		logic [EXTENT_BITS-1:0]               pc;
		logic [IDX_W-1:0]                     acc_nxt;

		if (j == 0) begin : g_head
			assign in_vld  = pop_valid;
			assign in_lst  = pop_last;
			assign in_crd  = pop_coord;
			assign in_dat  = pop_data;
			assign acc_nxt = IDX_W'(pc);
		end else begin : g_body
			assign in_vld  = vld_q[j-1];
			assign in_lst  = lst_q[j-1];
			assign in_crd  = crd_q[j-1];
			assign in_dat  = dat_q[j-1];
			// Multiply-add one output axis, keep the low index bits
			assign acc_nxt = IDX_W'(acc_q[j-1] * perm_ext[j] + IDX_W'(pc));
		end

		assign pc = perm_use[j] ? in_crd[perm_src[j]] : '0;

		// Advance the valid flag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_q[j] <= in_vld;
			end
		end

		// Advance the payload
		always_ff @(posedge clk) begin
			if (rdy[j]) begin
				acc_q[j] <= acc_nxt;
				crd_q[j] <= in_crd;
				dat_q[j] <= in_dat;
				lst_q[j] <= in_lst;
			end
		end
	end

	assign dst.valid      = vld_q[MAX_AXES-1];
	assign dst.dest_index = acc_q[MAX_AXES-1];
	assign dst.out_data   = dat_q[MAX_AXES-1];
	assign dst.last       = lst_q[MAX_AXES-1];

endmodule

`default_nettype wire

### rtl/tensor_permute_address_gen.sv
// Path: an accepted element is stored in the queue, then passes the index pipeline stages in order.
// Throughput: one element per cycle while dst.ready holds; the index pipeline spends one stage per output axis,
//   each stage one multiply-add of the running index by a permuted extent.
// A four-entry queue decouples the coordinate counters from the index pipeline.
// Reset: coordinates cleared, registers at their defaults, queue and pipeline empty.
`default_nettype none

module tensor_permute_address_gen #(
	parameter int MAX_AXES    = tpag_pkg::MAX_AXES_DEF,
	parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS_DEF,
	parameter int DATA_BITS   = tpag_pkg::DATA_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [tpag_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
	input  wire logic [tpag_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	tpag_in_if.sink                                src,
	tpag_out_if.source                             dst
);
	import tpag_pkg::*;

	localparam int AIW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int CRD_W = MAX_AXES * EXTENT_BITS;
	localparam int Q_W   = CRD_W + DATA_BITS + 1;

	logic [MAX_AXES-1:0]                  axis_use;
	logic [MAX_AXES-1:0][EXTENT_BITS:0]   ext_eff;
	logic [MAX_AXES-1:0][EXTENT_BITS:0]   perm_ext;
	logic [MAX_AXES-1:0][AIW-1:0]         perm_src;
	logic [MAX_AXES-1:0]                  perm_use;

	logic                                 push_valid;
	logic                                 push_ready;
	logic [MAX_AXES-1:0][EXTENT_BITS-1:0] push_coord;
	logic [DATA_BITS-1:0]                 push_data;
	logic                                 push_last;

	logic                                 pop_valid;
	logic                                 pop_ready;
	logic [Q_W-1:0]                       pop_word;
	logic [MAX_AXES-1:0][EXTENT_BITS-1:0] pop_coord;
	logic [DATA_BITS-1:0]                 pop_data;
	logic                                 pop_last;

	tpag_cfg #(
		.MAX_AXES    (MAX_AXES),
		.EXTENT_BITS (EXTENT_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_wr_index),
		.wr_data  (cfg_wr_data),
		.axis_use (axis_use),
		.ext_eff  (ext_eff),
		.perm_ext (perm_ext),
		.perm_src (perm_src),
		.perm_use (perm_use)
	);

	tpag_front #(
		.MAX_AXES    (MAX_AXES),
		.EXTENT_BITS (EXTENT_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.axis_use   (axis_use),
		.ext_eff    (ext_eff),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_coord (push_coord),
		.push_data  (push_data),
		.push_last  (push_last)
	);

	tpag_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_coord, push_data, push_last}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_word)
	);

	// Split the queue word back into its fields
	assign pop_coord = pop_word[Q_W-1 -: CRD_W];
	assign pop_data  = pop_word[DATA_BITS:1];
	assign pop_last  = pop_word[0];

	tpag_back #(
		.MAX_AXES    (MAX_AXES),
		.EXTENT_BITS (EXTENT_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_coord (pop_coord),
		.pop_data  (pop_data),
		.pop_last  (pop_last),
		.perm_ext  (perm_ext),
		.perm_src  (perm_src),
		.perm_use  (perm_use),
		.dst       (dst)
	);

endmodule

`default_nettype wire
